// ===== rtl/lmg_pkg.sv =====
// Shared types and constants for the multi-stop linear gradient block.
`timescale 1ns / 1ps
package lmg_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_EASE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_FEW      = 2'd3;

   localparam logic [1:0] EASE_LINEAR = 2'd0;
   localparam logic [1:0] EASE_SMOOTH = 2'd1;
   localparam logic [1:0] EASE_LEGACY = 2'd2;
   localparam logic [1:0] EASE_BAD    = 2'd3;

   localparam logic [2:0] REG_WIDTH   = 3'd0;
   localparam logic [2:0] REG_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_DIR_X   = 3'd2;
   localparam logic [2:0] REG_DIR_Y   = 3'd3;
   localparam logic [2:0] REG_LENGTH  = 3'd4;
   localparam logic [2:0] REG_EASING  = 3'd5;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // One stop table entry.
   typedef struct packed {
      logic [16:0] offset;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        ease_given;
      logic [1:0]  easing;
   } stop_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;       // empty the table
      logic ins_start;   // begin insert: shift pointer at end
      logic ins_shift;   // move one entry up
      logic ins_write;   // place the new stop
      logic geo_start;   // latch pixel, compute geometry
      logic div_pos;     // start position division
      logic search_init; // reset the stop search
      logic search_step; // compare one entry
      logic brk_load;    // load bracketing stops
      logic div_raw;     // start amount division
      logic ease1;       // latch the raw amount for easing
      logic ease2;       // easing multiply stage one
      logic ease3;       // easing multiply stage two
      logic mix;         // final easing and channel interpolation
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic few;
      logic ins_done;
      logic div_busy;
      logic search_done;
   } sts_type;

endpackage

// ===== rtl/lmg_divider.sv =====
// Restoring divider, one quotient bit per cycle, with saturation; the caller adds the rounding to the numerator.
`timescale 1ns / 1ps
module lmg_divider
   import lmg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] numer,   // numerator already scaled and rounded up
   input  logic [32:0] denom,
   output logic        busy,
   output logic [16:0] quot      // saturated to one in Q1.16
);
   logic [47:0] rem_ff, rem_in;
   logic [47:0] q_ff, q_in;
   logic [32:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [48:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = '0;
      if (start) begin
         rem_in  = '0;
         q_in    = numer;
         den_in  = denom;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, q_ff[47]} - {16'd0, den_ff};
         if (!trial[48]) begin
            rem_in = trial[47:0];
            q_in   = {q_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[46:0], q_ff[47]};
            q_in   = {q_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = (q_ff > 48'h10000) ? ONE_Q16 : q_ff[16:0];

   assert property (@(posedge clock) disable iff (reset) start |=> busy)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) busy |-> cnt_ff != 6'd0)
      else $error("divider busy with zero count");
   assert property (@(posedge clock) disable iff (reset) !busy && !start |=> !busy)
      else $error("divider woke by itself");
endmodule

// ===== rtl/lmg_datapath.sv =====
// Datapath: stop table, geometry, search, division, easing and color mixing.
`timescale 1ns / 1ps
module lmg_datapath
   import lmg_pkg::*;
#(
   parameter int MAX_STOPS     = 16,
   parameter int MAX_DIMENSION = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  stop_type      new_stop,
   input  logic [11:0]   pixel_x,
   input  logic [11:0]   pixel_y,
   input  logic [12:0]   cfg_width,
   input  logic [12:0]   cfg_height,
   input  logic [15:0]   cfg_dir_x,
   input  logic [15:0]   cfg_dir_y,
   input  logic [23:0]   cfg_length,
   input  logic [1:0]    cfg_easing,
   output logic [7:0]    mix_red,
   output logic [7:0]    mix_green,
   output logic [7:0]    mix_blue,
   output logic [7:0]    mix_alpha
);
   localparam int IW = $clog2(MAX_STOPS);
   localparam int CW = $clog2(MAX_STOPS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STOPS);
   localparam logic [17:0] MAX_DIM = 18'(MAX_DIMENSION);

   stop_type table_ff [MAX_STOPS];
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] ptr_ff, ptr_in;   // insert pointer, also search index
   logic          found_ff, found_in;

   // Geometry, bracketing and easing registers.
   logic signed [18:0] cx2_ff, cy2_ff;
   logic signed [16:0] dx_ff, dy_ff;
   logic [16:0] wm1_ff, hm1_ff;
   logic signed [37:0] px_ff, py_ff;
   logic [35:0] ex_ff, ey_ff;
   logic [2:0]  geo_ff;
   logic [16:0] pos_ff;
   stop_type    lo_ff, hi_ff;
   logic [16:0] raw_ff;
   logic [33:0] tt_ff;
   logic [18:0] k_ff;
   logic [16:0] e_ff;
   logic [52:0] cub_ff;

   logic div_busy;
   logic [16:0] div_q;
   logic [47:0] div_num;
   logic [32:0] div_den;
   logic        div_go;

   // Table write and insertion shift.
   stop_type prev_entry;
   assign prev_entry = table_ff[IW'(ptr_ff - CW'(1))];

   always_ff @(posedge clock) begin
      if (cmd.ins_shift) table_ff[IW'(ptr_ff)] <= prev_entry;
      if (cmd.ins_write) table_ff[IW'(ptr_ff)] <= new_stop;
   end

   logic [16:0] cur_off;
   assign cur_off = table_ff[IW'(ptr_ff)].offset;

   always_comb begin
      held_in  = held_ff;
      ptr_in   = ptr_ff;
      found_in = found_ff;
      if (cmd.clear) held_in = '0;
      if (cmd.ins_start) ptr_in = held_ff;
      if (cmd.ins_shift) ptr_in = ptr_ff - CW'(1);
      if (cmd.ins_write) held_in = held_ff + CW'(1);
      if (cmd.search_init) begin
         ptr_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.search_step && !found_in) begin
         if (cur_off < pos_ff && ptr_ff != held_ff - CW'(1)) ptr_in = ptr_ff + CW'(1);
         else found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         ptr_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         held_ff  <= held_in;
         ptr_ff   <= ptr_in;
         found_ff <= found_in;
      end
   end

   // Geometry over three steps: operands, products, sums.
   logic [12:0] w_eff, h_eff;
   always_comb begin
      w_eff = (cfg_width == '0) ? 13'd1 : cfg_width;
      if (18'(cfg_width) > MAX_DIM) w_eff = 13'(MAX_DIM);
      h_eff = (cfg_height == '0) ? 13'd1 : cfg_height;
      if (18'(cfg_height) > MAX_DIM) h_eff = 13'(MAX_DIM);
   end

   logic [35:0] ext_sum;
   logic [35:0] ext_val;
   logic signed [38:0] dot_num;
   assign ext_sum = ex_ff + ey_ff;
   assign ext_val = (ext_sum == '0) ? 36'd32768 : ext_sum;
   assign dot_num = 39'(px_ff) + 39'(py_ff) + 39'($signed({1'b0, ext_val}));

   always_ff @(posedge clock) begin
      if (reset) geo_ff <= '0;
      else if (cmd.geo_start) geo_ff <= 3'b001;
      else geo_ff <= {geo_ff[1:0], 1'b0};
      if (cmd.geo_start) begin
         cx2_ff <= (w_eff == 13'd1) ? '0 : $signed({6'd0, pixel_x, 1'b0}) - $signed(19'(w_eff) - 19'sd1);
         cy2_ff <= (h_eff == 13'd1) ? '0 : $signed({6'd0, pixel_y, 1'b0}) - $signed(19'(h_eff) - 19'sd1);
         dx_ff  <= 17'($signed(cfg_dir_x));
         dy_ff  <= 17'($signed(cfg_dir_y));
         wm1_ff <= (w_eff > 13'd1) ? 17'(w_eff - 13'd1) : 17'd1;
         hm1_ff <= (h_eff > 13'd1) ? 17'(h_eff - 13'd1) : 17'd1;
      end
      if (geo_ff[0]) begin
         px_ff <= 38'(cx2_ff * dx_ff);
         py_ff <= 38'(cy2_ff * dy_ff);
         ex_ff <= 36'(17'(dx_ff < 0 ? -dx_ff : dx_ff) * wm1_ff);
         ey_ff <= 36'(17'(dy_ff < 0 ? -dy_ff : dy_ff) * hm1_ff);
      end
   end

   // Shared divider feeds.
   logic [32:0] len_val;
   logic [16:0] span;
   assign len_val = (cfg_length != '0) ? {2'd0, cfg_length, 7'd0} : 33'({ext_val, 1'b0});
   assign span    = hi_ff.offset - lo_ff.offset;

   always_comb begin
      div_go  = 1'b0;
      div_num = '0;
      div_den = 33'd1;
      if (cmd.div_pos) begin
         div_go  = 1'b1;
         div_den = len_val;
         div_num = (dot_num <= 0) ? '0 : 48'({dot_num[37:0], 16'd0} + 54'(len_val[32:1]));
      end else if (cmd.div_raw) begin
         div_go  = 1'b1;
         div_den = 33'(span);
         div_num = 48'({17'(pos_ff - lo_ff.offset), 16'd0} + 33'(span[16:1]));
      end
   end

   lmg_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .numer (div_num),
      .denom (div_den),
      .busy  (div_busy),
      .quot  (div_q)
   );

   // Easing: t*t, then cubic = tt*(3*65536 - 2t), then rounding; legacy averages with t, linear uses t.
   logic [1:0] mode;
   always_comb begin
      if (hi_ff.ease_given) mode = hi_ff.easing;
      else if (lo_ff.ease_given) mode = lo_ff.easing;
      else mode = cfg_easing;
   end

   logic [63:0] lin_ext;
   assign lin_ext = {15'd0, raw_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (cmd.div_raw || cmd.brk_load) pos_ff <= pos_ff;
      if (cmd.search_init) pos_ff <= div_q;
      if (cmd.brk_load) begin
         hi_ff <= table_ff[IW'(ptr_ff)];
         lo_ff <= table_ff[IW'((ptr_ff == '0) ? '0 : ptr_ff - CW'(1))];
      end
      if (cmd.ease1) begin
         raw_ff <= (span == '0) ? '0 : div_q;
         tt_ff  <= '0;
      end
      if (cmd.ease2) begin
         tt_ff <= 34'(raw_ff * raw_ff);
         k_ff  <= 19'd196608 - 19'({raw_ff, 1'b0});
      end
      if (cmd.ease3) cub_ff <= 53'(tt_ff * k_ff);
      if (cmd.mix) begin
         unique case (mode)
            EASE_SMOOTH: e_ff <= 17'((64'(cub_ff) + 64'h8000_0000) >> 32);
            EASE_LEGACY: e_ff <= 17'((lin_ext + 64'(cub_ff) + 64'h1_0000_0000) >> 33);
            default:     e_ff <= raw_ff;
         endcase
      end
   end

   function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                        input logic [16:0] e);
      logic [25:0] v;
      v = 26'(a * (ONE_Q16 - e)) + 26'(b * e) + 26'd32768;
      return v[23:16];
   endfunction

   assign mix_red   = blend(lo_ff.red,   hi_ff.red,   e_ff);
   assign mix_green = blend(lo_ff.green, hi_ff.green, e_ff);
   assign mix_blue  = blend(lo_ff.blue,  hi_ff.blue,  e_ff);
   assign mix_alpha = blend(lo_ff.alpha, hi_ff.alpha, e_ff);

   assign sts.full        = (held_ff >= MAX_CNT);
   assign sts.few         = (held_ff < CW'(2));
   assign sts.ins_done    = (ptr_ff == '0) || (prev_entry.offset <= new_stop.offset);
   assign sts.div_busy    = div_busy;
   assign sts.search_done = found_ff;

   assert property (@(posedge clock) disable iff (reset) held_ff <= MAX_CNT)
      else $error("stop count beyond table size");
   assert property (@(posedge clock) disable iff (reset) cmd.ins_write |=> held_ff == $past(held_ff) + CW'(1))
      else $error("insert did not count");
   assert property (@(posedge clock) disable iff (reset) cmd.clear |=> held_ff == '0)
      else $error("clear did not empty table");
endmodule

// ===== rtl/lmg_control.sv =====
// Controller state machine that sequences insertions and pixel samples.
`timescale 1ns / 1ps
module lmg_control
   import lmg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  operation,
   input  logic        ease_given,
   input  logic [1:0]  easing,
   input  sts_type     sts,
   output cmd_type     cmd,
   output logic        busy,
   output logic        done,
   output logic        ok_color,
   output logic [1:0]  status
);
   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_SHIFT  = 12'b000000000010,
      S_GEO    = 12'b000000000100,
      S_DIVP   = 12'b000000001000,
      S_WAITP  = 12'b000000010000,
      S_SRCH   = 12'b000000100000,
      S_BRK    = 12'b000001000000,
      S_WAITR  = 12'b000010000000,
      S_E1     = 12'b000100000000,
      S_E2     = 12'b001000000000,
      S_E3     = 12'b010000000000,
      S_MIX    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      done_ff, done_in;
   logic      okc_ff, okc_in;
   logic [1:0] stat_ff, stat_in;
   logic [1:0] gwait_ff, gwait_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      done_in  = 1'b0;
      okc_in   = 1'b0;
      stat_in  = ST_OK;
      gwait_in = gwait_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (operation)
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     done_in   = 1'b1;
                  end
                  OP_ADD: begin
                     if (ease_given && easing == EASE_BAD) begin
                        stat_in = ST_BAD_EASE;
                        done_in = 1'b1;
                     end else if (sts.full) begin
                        stat_in = ST_FULL;
                        done_in = 1'b1;
                     end else begin
                        cmd.ins_start = 1'b1;
                        state_in      = S_SHIFT;
                     end
                  end
                  OP_SAMPLE: begin
                     if (sts.few) begin
                        stat_in = ST_FEW;
                        done_in = 1'b1;
                     end else begin
                        cmd.geo_start = 1'b1;
                        gwait_in      = 2'd2;
                        state_in      = S_GEO;
                     end
                  end
                  default: done_in = 1'b1;
               endcase
            end
         end
         S_SHIFT: begin
            if (sts.ins_done) begin
               cmd.ins_write = 1'b1;
               done_in       = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.ins_shift = 1'b1;
            end
         end
         S_GEO: begin
            gwait_in = gwait_ff - 2'd1;
            if (gwait_ff == 2'd0) state_in = S_DIVP;
         end
         S_DIVP: begin
            cmd.div_pos = 1'b1;
            state_in    = S_WAITP;
         end
         S_WAITP: begin
            if (!sts.div_busy) begin
               cmd.search_init = 1'b1;
               state_in        = S_SRCH;
            end
         end
         S_SRCH: begin
            if (sts.search_done) state_in = S_BRK;
            else cmd.search_step = 1'b1;
         end
         S_BRK: begin
            cmd.brk_load = 1'b1;
            state_in     = S_WAITR;
            gwait_in     = 2'd0;
         end
         S_WAITR: begin
            if (gwait_ff == 2'd0) begin
               cmd.div_raw = 1'b1;
               gwait_in    = 2'd1;
            end else if (!sts.div_busy) begin
               state_in = S_E1;
            end
         end
         S_E1: begin
            cmd.ease1 = 1'b1;
            state_in  = S_E2;
         end
         S_E2: begin
            cmd.ease2 = 1'b1;
            state_in  = S_E3;
         end
         S_E3: begin
            cmd.ease3 = 1'b1;
            state_in  = S_MIX;
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            done_in  = 1'b1;
            okc_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         okc_ff   <= 1'b0;
         stat_ff  <= ST_OK;
         gwait_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         okc_ff   <= okc_in;
         stat_ff  <= stat_in;
         gwait_ff <= gwait_in;
      end
   end

   assign busy     = (state_ff != S_IDLE);
   assign done     = done_ff;
   assign ok_color = okc_ff;
   assign status   = stat_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !(okc_ff && stat_ff != ST_OK))
      else $error("color with error status");
   assert property (@(posedge clock) disable iff (reset) okc_ff |-> done_ff)
      else $error("color without result");
   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state register not one-hot");
endmodule

// ===== rtl/linear_multistop_gradient.sv =====
// Top level of the multi-stop linear gradient generator.
`timescale 1ns / 1ps
// Clear, unused and rejected items are answered from the idle state through the done and
// output registers; adding a stop runs the insertion shift, one entry per cycle.
// A pixel sample runs the geometry, two 48-step divisions on one shared divider, a
// stop search, and three easing steps before the mix.
// Items are taken one at a time; results appear for one cycle on rsp_valid.
// Synchronous reset empties the stop table count and loads register defaults.
module linear_multistop_gradient
   import lmg_pkg::*;
#(
   parameter int MAX_STOPS     = 16,
   parameter int MAX_DIMENSION = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_operation,
   input  logic [16:0]  req_stop_offset,
   input  logic [7:0]   req_stop_red,
   input  logic [7:0]   req_stop_green,
   input  logic [7:0]   req_stop_blue,
   input  logic [7:0]   req_stop_alpha,
   input  logic         req_stop_ease_given,
   input  logic [1:0]   req_stop_easing,
   input  logic [11:0]  req_pixel_x,
   input  logic [11:0]  req_pixel_y,
   output logic         rsp_valid,
   output logic [7:0]   rsp_red,
   output logic [7:0]   rsp_green,
   output logic [7:0]   rsp_blue,
   output logic [7:0]   rsp_alpha,
   output logic [1:0]   rsp_status,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_data
);
   logic [12:0] width_ff, height_ff;
   logic [15:0] dir_x_ff, dir_y_ff;
   logic [23:0] length_ff;
   logic [1:0]  easing_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd1;
         height_ff <= 13'd1;
         dir_x_ff  <= 16'd0;
         dir_y_ff  <= 16'hC000;
         length_ff <= '0;
         easing_ff <= EASE_LINEAR;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff  <= csr_data[12:0];
            REG_HEIGHT: height_ff <= csr_data[12:0];
            REG_DIR_X:  dir_x_ff  <= csr_data[15:0];
            REG_DIR_Y:  dir_y_ff  <= csr_data[15:0];
            REG_LENGTH: length_ff <= csr_data;
            REG_EASING: easing_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // Latch the request so the datapath sees a stable item.
   stop_type    stop_ff;
   logic [11:0] px_ff, py_ff;
   logic        accept;
   stop_type    cur_stop;
   assign accept = start && !busy;

   always_comb begin
      cur_stop.offset     = (req_stop_offset > ONE_Q16) ? ONE_Q16 : req_stop_offset;
      cur_stop.red        = req_stop_red;
      cur_stop.green      = req_stop_green;
      cur_stop.blue       = req_stop_blue;
      cur_stop.alpha      = req_stop_alpha;
      cur_stop.ease_given = req_stop_ease_given;
      cur_stop.easing     = req_stop_easing;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stop_ff <= cur_stop;
         px_ff   <= req_pixel_x;
         py_ff   <= req_pixel_y;
      end
   end

   cmd_type cmd;
   sts_type sts;
   logic    done, ok_color;
   logic [1:0] status;
   logic [7:0] mr, mg, mb, ma;

   lmg_control u_ctl (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .operation  (req_operation),
      .ease_given (req_stop_ease_given),
      .easing     (req_stop_easing),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .done       (done),
      .ok_color   (ok_color),
      .status     (status)
   );

   // Geometry starts in the accept cycle, so feed the live pixel then.
   lmg_datapath #(
      .MAX_STOPS     (MAX_STOPS),
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .new_stop   (stop_ff),
      .pixel_x    (cmd.geo_start ? req_pixel_x : px_ff),
      .pixel_y    (cmd.geo_start ? req_pixel_y : py_ff),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .cfg_dir_x  (dir_x_ff),
      .cfg_dir_y  (dir_y_ff),
      .cfg_length (length_ff),
      .cfg_easing (easing_ff),
      .mix_red    (mr),
      .mix_green  (mg),
      .mix_blue   (mb),
      .mix_alpha  (ma)
   );

   // The mix step registers e; colors are valid from the next cycle on.
   logic       out_v_ff;
   logic       out_c_ff;
   logic [1:0] out_s_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else out_v_ff <= done;
      out_c_ff <= ok_color;
      out_s_ff <= status;
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_status = out_s_ff;
   assign rsp_red    = out_c_ff ? mr : 8'd0;
   assign rsp_green  = out_c_ff ? mg : 8'd0;
   assign rsp_blue   = out_c_ff ? mb : 8'd0;
   assign rsp_alpha  = out_c_ff ? ma : 8'd0;

   assert property (@(posedge clock) disable iff (reset) accept |=> busy || done)
      else $error("accepted item neither running nor answered");
   assert property (@(posedge clock) disable iff (reset) done |=> rsp_valid)
      else $error("finished item not presented");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_status != ST_OK |->
                    {rsp_red, rsp_green, rsp_blue, rsp_alpha} == 32'd0)
      else $error("color on a failed result");
endmodule
